// ===== rtl/json_number_scanner_assert.svh =====
// Assertion macros for the number scanner top level.
// Depends on nothing; included by json_number_scanner.sv.
`ifndef JSON_NUMBER_SCANNER_ASSERT_SVH
`define JSON_NUMBER_SCANNER_ASSERT_SVH
`define JNS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define JNS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/jns_pkg.sv =====
// Shared types and codes for the number scanner.
// No dependencies.
package jns_pkg;
  typedef enum logic [10:0] {
    PH_START      = 11'b00000000001,
    PH_AFTER_SIGN = 11'b00000000010,
    PH_INT        = 11'b00000000100,
    PH_FRAC_FIRST = 11'b00000001000,
    PH_FRAC       = 11'b00000010000,
    PH_ZERO       = 11'b00000100000,
    PH_ZPT_FIRST  = 11'b00001000000,
    PH_ZLEAD      = 11'b00010000000,
    PH_EXP_SIGN   = 11'b00100000000,
    PH_EXP_FIRST  = 11'b01000000000,
    PH_EXP        = 11'b10000000000
  } phase_t;

  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_FLOAT = 3'd1;
  localparam logic [2:0] KIND_MISS  = 3'd2;
  localparam logic [2:0] KIND_ZPT   = 3'd3;
  localparam logic [2:0] KIND_EOVF  = 3'd4;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // finished number handed from the front to the back
  typedef struct packed {
    logic        err;
    logic [2:0]  err_kind;
    logic        neg;
    logic        fe_seen;
    logic        use_exp;
    logic        exp_sign;
    logic [63:0] mant;
    logic [63:0] exp_acc;
    logic [63:0] exp_val;
  } scan_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        neg;
    logic [63:0] mant;
    logic [63:0] dexp;
  } res_t;
endpackage

// ===== rtl/jns_front.sv =====
// Front part: byte grammar and accumulators, emits one record per number.
// Depends on jns_pkg.
module jns_front #(
  parameter int SIG_DIGITS_MAX = 19
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     char_in,
  output logic           rec_valid,
  output jns_pkg::scan_t rec
);
  jns_pkg::phase_t phase, phase_next;
  logic        sign_seen, sign_next;
  logic [63:0] mant, mant_next;
  logic [4:0]  sig_count, sig_next;
  logic [63:0] exp_acc, exp_acc_next;
  logic [63:0] exp_val, exp_val_next;
  logic        exp_sign, exp_sign_next;
  logic        fe_seen, fe_next;

  logic       dig, is_e, can_sig;
  logic [3:0] d;
  logic       emit, emit_err;
  logic [2:0] ekind;
  logic [63:0] inc_e, dec_e, mant10, ev10;

  assign dig = char_in >= 8'h30 && char_in <= 8'h39;
  assign d = dig ? 4'(char_in - 8'h30) : 4'd0;
  assign is_e = char_in == 8'h65 || char_in == 8'h45;
  assign can_sig = sig_count < 5'(SIG_DIGITS_MAX);
  assign mant10 = (mant << 3) + (mant << 1) + 64'(d);
  assign inc_e = (exp_acc == jns_pkg::S64_MAX) ? exp_acc : exp_acc + 64'd1;
  assign dec_e = (exp_acc == {1'b1, 63'd0}) ? exp_acc : exp_acc - 64'd1;
  assign ev10 = (exp_val << 3) + (exp_val << 1) + 64'(d);

  always_comb begin
    phase_next = phase;
    sign_next = sign_seen;
    mant_next = mant;
    sig_next = sig_count;
    exp_acc_next = exp_acc;
    exp_val_next = exp_val;
    exp_sign_next = exp_sign;
    fe_next = fe_seen;
    emit = 1'b0;
    emit_err = 1'b0;
    ekind = jns_pkg::KIND_MISS;
    case (phase)
      jns_pkg::PH_START, jns_pkg::PH_AFTER_SIGN: begin
        if (phase == jns_pkg::PH_START && char_in == 8'h2D) begin
          sign_next = 1'b1;
          phase_next = jns_pkg::PH_AFTER_SIGN;
        end else if (char_in == 8'h30) begin
          phase_next = jns_pkg::PH_ZERO;
        end else if (dig) begin
          phase_next = jns_pkg::PH_INT;
          if (can_sig) begin
            mant_next = mant10;
            sig_next = sig_count + 5'd1;
          end else exp_acc_next = inc_e;
        end else emit_err = 1'b1;
      end
      jns_pkg::PH_INT: begin
        if (dig) begin
          if (can_sig) begin
            mant_next = mant10;
            sig_next = sig_count + 5'd1;
          end else exp_acc_next = inc_e;
        end else if (char_in == 8'h2E) begin
          fe_next = 1'b1;
          phase_next = jns_pkg::PH_FRAC_FIRST;
        end else if (is_e) begin
          fe_next = 1'b1;
          phase_next = jns_pkg::PH_EXP_SIGN;
        end else emit = 1'b1;
      end
      jns_pkg::PH_FRAC_FIRST, jns_pkg::PH_FRAC, jns_pkg::PH_ZPT_FIRST,
      jns_pkg::PH_ZLEAD: begin
        if ((phase == jns_pkg::PH_ZPT_FIRST || phase == jns_pkg::PH_ZLEAD)
            && char_in == 8'h30) begin
          exp_acc_next = dec_e;
          phase_next = jns_pkg::PH_ZLEAD;
        end else if (dig) begin
          phase_next = jns_pkg::PH_FRAC;
          if (can_sig) begin
            mant_next = mant10;
            sig_next = sig_count + 5'd1;
            exp_acc_next = dec_e;
          end
        end else if (phase == jns_pkg::PH_FRAC_FIRST) begin
          emit_err = 1'b1;
        end else if (phase == jns_pkg::PH_ZPT_FIRST) begin
          emit_err = 1'b1;
          ekind = jns_pkg::KIND_ZPT;
        end else if (is_e) begin
          fe_next = 1'b1;
          phase_next = jns_pkg::PH_EXP_SIGN;
        end else emit = 1'b1;
      end
      jns_pkg::PH_ZERO: begin
        if (char_in == 8'h2E) begin
          fe_next = 1'b1;
          phase_next = jns_pkg::PH_ZPT_FIRST;
        end else if (is_e) begin
          fe_next = 1'b1;
          phase_next = jns_pkg::PH_EXP_SIGN;
        end else emit = 1'b1;
      end
      jns_pkg::PH_EXP_SIGN, jns_pkg::PH_EXP_FIRST, jns_pkg::PH_EXP: begin
        if (phase == jns_pkg::PH_EXP_SIGN && char_in == 8'h2D) begin
          exp_sign_next = 1'b1;
          phase_next = jns_pkg::PH_EXP_FIRST;
        end else if (phase == jns_pkg::PH_EXP_SIGN && char_in == 8'h2B) begin
          phase_next = jns_pkg::PH_EXP_FIRST;
        end else if (dig) begin
          phase_next = jns_pkg::PH_EXP;
          // saturated value 2^63 marks overflow and sticks
          if (!exp_val[63]) begin
            if (exp_val > 64'd922337203685477580 ||
                (exp_val == 64'd922337203685477580 && d > 4'd7))
              exp_val_next = {1'b1, 63'd0};
            else exp_val_next = ev10;
          end
        end else if (phase == jns_pkg::PH_EXP) begin
          emit = 1'b1;
        end else emit_err = 1'b1;
      end
      default: emit_err = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else begin
      rec_valid <= in_valid && (emit || emit_err);
    end
    if (in_valid) begin
      rec.err <= emit_err;
      rec.err_kind <= ekind;
      rec.neg <= sign_seen;
      rec.fe_seen <= fe_seen;
      rec.use_exp <= phase == jns_pkg::PH_EXP;
      rec.exp_sign <= exp_sign;
      rec.mant <= mant;
      rec.exp_acc <= exp_acc;
      rec.exp_val <= exp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_valid && (emit || emit_err))) begin
      phase <= jns_pkg::PH_START;
      sign_seen <= 1'b0;
      mant <= 64'd0;
      sig_count <= 5'd0;
      exp_acc <= 64'd0;
      exp_val <= 64'd0;
      exp_sign <= 1'b0;
      fe_seen <= 1'b0;
    end else if (in_valid) begin
      phase <= phase_next;
      sign_seen <= sign_next;
      mant <= mant_next;
      sig_count <= sig_next;
      exp_acc <= exp_acc_next;
      exp_val <= exp_val_next;
      exp_sign <= exp_sign_next;
      fe_seen <= fe_next;
    end
  end
endmodule

// ===== rtl/jns_back.sv =====
// Back part: exponent sum, kind decision, result build.
// Depends on jns_pkg.
module jns_back (
  input  jns_pkg::scan_t rec,
  output jns_pkg::res_t  res
);
  logic [63:0] v, sum, e;
  logic        ovf;

  assign v = rec.exp_sign ? (64'd0 - rec.exp_val) : rec.exp_val;
  assign sum = rec.exp_acc + v;
  assign ovf = (rec.exp_acc[63] == v[63]) && (sum[63] != rec.exp_acc[63]);

  always_comb begin
    if (!rec.use_exp) e = rec.exp_acc;
    else if (ovf) e = rec.exp_acc[63] ? {1'b1, 63'd0} : jns_pkg::S64_MAX;
    else e = sum;
    res.neg = rec.neg;
    if (rec.err || (rec.use_exp && rec.exp_val[63])) begin
      res.kind = rec.err ? rec.err_kind : jns_pkg::KIND_EOVF;
      res.mant = 64'd0;
      res.dexp = 64'd0;
    end else begin
      res.mant = rec.mant;
      res.dexp = e;
      res.kind = (rec.fe_seen || e != 64'd0 ||
                  rec.mant > jns_pkg::S64_MAX + 64'(rec.neg))
                 ? jns_pkg::KIND_FLOAT : jns_pkg::KIND_INT;
    end
  end
endmodule

// ===== rtl/jns_queue.sv =====
// Small record queue between the front and the back.
// Depends on jns_pkg.
module jns_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  jns_pkg::scan_t wdata,
  input  logic           rd,
  output logic           empty,
  output logic           almost_full,
  output jns_pkg::scan_t rdata
);
  jns_pkg::scan_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign empty = cnt == 3'd0;
  assign almost_full = cnt >= 3'd2;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= 2'd0;
      rp <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end
endmodule

// ===== rtl/json_number_scanner.sv =====
// Number scanner: one byte per cycle while full is low, records via a 4-entry queue.
// A result reaches the ports via the front's record register and then the queue.
// Throughput: 1 byte per cycle while full is low; full rises when 2 records wait unread.
// Synchronous active-high reset: parser to start of number, queue empty.
// Depends on jns_pkg, jns_front, jns_back, jns_queue, assert header.
`include "json_number_scanner_assert.svh"
module json_number_scanner #(
  parameter int SIG_DIGITS_MAX = 19
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic        is_negative,
  output logic [63:0] mantissa,
  output logic signed [63:0] decimal_exponent
);
  logic           acc, rec_valid, q_rd;
  jns_pkg::scan_t rec, q_out;
  jns_pkg::res_t  res;

  assign acc = push && !full;
  assign q_rd = pop && !empty;

  jns_front #(.SIG_DIGITS_MAX(SIG_DIGITS_MAX)) u_front (
    .clk(clk), .rst(rst), .in_valid(acc), .char_in(char_in),
    .rec_valid(rec_valid), .rec(rec)
  );
  jns_queue u_queue (
    .clk(clk), .rst(rst), .wr(rec_valid), .wdata(rec), .rd(q_rd),
    .empty(empty), .almost_full(full), .rdata(q_out)
  );
  jns_back u_back (.rec(q_out), .res(res));

  assign kind = res.kind;
  assign is_negative = res.neg;
  assign mantissa = res.mant;
  assign decimal_exponent = res.dexp;

  `JNS_ASSERT_NXT(a_rec_needs_item, clk, rst, !acc, !rec_valid)
  `JNS_ASSERT_IMP(a_kind_range, clk, rst, !empty, kind <= jns_pkg::KIND_EOVF)
  `JNS_ASSERT_IMP(a_err_zero, clk, rst, !empty && kind >= jns_pkg::KIND_MISS,
                  mantissa == 64'd0 && decimal_exponent == 64'd0)
endmodule
